FILE: design/tpm_pkg.sv
// shared types, widths and helpers of the ternary pattern memory match block
// no dependencies; used by tpm_lane, tpm_merge_tree and the top level
`default_nettype none

package tpm_pkg;

    localparam int ELEM_COUNT     = 8;
    localparam int ELEM_W         = 2;
    localparam int PAT_W          = ELEM_COUNT * ELEM_W;
    localparam int SCORE_W        = 5;
    localparam int ACT_W          = 4;
    localparam int SLOT_IDX_W     = 4;
    localparam int OUT_DATA_W     = 16;
    localparam int SLOT_COUNT_DEF = 16;

    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    typedef struct packed {
        logic                         have;
        logic signed [SCORE_W-1:0]    score;
        logic [ACT_W-1:0]             active;
        logic [SLOT_IDX_W-1:0]        slot;
    } t_node;

    typedef struct packed {
        logic                         found;
        logic                         full;
        logic signed [SCORE_W-1:0]    score;
        logic [ACT_W-1:0]             active;
        logic [SLOT_IDX_W-1:0]        slot;
    } t_result;

    function automatic int tree_depth(input int slots);
        return (slots > 1) ? $clog2(slots) : 0;
    endfunction

    // right replaces left when right has a node and left has none, or on a strictly greater ratio
    function automatic t_node pick(input t_node l, input t_node r);
        logic signed [SCORE_W+ACT_W:0] prod_r;
        logic signed [SCORE_W+ACT_W:0] prod_l;
        logic                          better;
        prod_r = r.score * $signed({1'b0, l.active});
        prod_l = l.score * $signed({1'b0, r.active});
        better = r.have && (!l.have || (prod_r > prod_l));
        return better ? r : l;
    endfunction

endpackage

`default_nettype wire

FILE: design/tpm_lane.sv
// one scoring lane: compares the query against one stored slot
// depends on tpm_pkg
`default_nettype none

module tpm_lane (
    input  wire logic [tpm_pkg::PAT_W-1:0]      i_query,
    input  wire logic [tpm_pkg::PAT_W-1:0]      i_word,
    input  wire logic                           i_valid,
    input  wire logic [tpm_pkg::SLOT_IDX_W-1:0] i_slot,
    output tpm_pkg::t_node                      o_node
);
    import tpm_pkg::*;

    logic signed [SCORE_W-1:0] score_sum;
    logic [ACT_W-1:0]          active_cnt;
    logic [ELEM_W-1:0]         q_code;
    logic [ELEM_W-1:0]         w_code;
    logic                      have;

    always_comb begin
        score_sum  = '0;
        active_cnt = '0;
        q_code     = '0;
        w_code     = '0;
        for (int e = 0; e < ELEM_COUNT; e++) begin
            q_code = i_query[e*ELEM_W +: ELEM_W];
            w_code = i_word[e*ELEM_W +: ELEM_W];
            if ((q_code != '0) || (w_code != '0)) begin
                active_cnt = active_cnt + ACT_W'(1);
                if (q_code == w_code) begin
                    score_sum = score_sum + SCORE_W'(1);
                end else begin
                    score_sum = score_sum - SCORE_W'(1);
                end
            end
        end
    end

    assign have = i_valid && (active_cnt != '0);

    always_comb begin
        o_node.have   = have;
        o_node.score  = have ? score_sum : '0;
        o_node.active = have ? active_cnt : '0;
        o_node.slot   = have ? i_slot : '0;
    end

endmodule

`default_nettype wire

FILE: design/tpm_merge_tree.sv
// registered compare tree that merges the lane results into the best slot
// depends on tpm_pkg (node type, ratio compare, tree depth)
`default_nettype none

module tpm_merge_tree #(
    parameter int SLOT_COUNT = tpm_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire tpm_pkg::t_node [SLOT_COUNT-1:0]    i_leaf,
    output tpm_pkg::t_node                          o_root
);
    import tpm_pkg::*;

    localparam int LEVELS = tree_depth(SLOT_COUNT);
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;

    t_node r_node [NODES];
    t_node leaf_pad [LEAVES];

    for (genvar s = 0; s < LEAVES; s++) begin : g_pad
        if (s < SLOT_COUNT) begin : g_used
            assign leaf_pad[s] = i_leaf[s];
        end else begin : g_empty
            assign leaf_pad[s] = '0;
        end
    end

    // heap layout: node i has children 2i+1 and 2i+2, leaves at the end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LEAVES - 1; i++) begin
            r_node[i] <= pick(r_node[2*i+1], r_node[2*i+2]);
        end
        for (int s = 0; s < LEAVES; s++) begin
            r_node[LEAVES-1+s] <= leaf_pad[s];
        end
    end

    assign o_root = r_node[0];

endmodule

`default_nettype wire

FILE: design/ternary_pattern_memory_match.sv
// ternary pattern memory with best-match query: slot store, lanes, merge tree, control
// depends on tpm_pkg, tpm_lane and tpm_merge_tree
//
// usage
// - requests enter on the s_axis channel: tuser = request kind (0 query, 1 store),
//   tdata = eight 2-bit ternary elements, element 0 in the lowest bits
// - one result per request leaves on the m_axis channel: tuser = {table_full, found},
//   tdata = {3'b0, slot_index, best_active, best_score}
// - a store writes the pattern into the lowest free slot in the busy state after
//   acceptance; its result is loaded into the output register in the same cycle
// - a query scores all slots at once, one lane per slot, then a registered compare
//   tree of clog2(SLOT_COUNT) levels picks the best ratio; the result is loaded into the
//   output register once the counter shows that the tree root holds it
// - one request is in flight at a time; the next is accepted in the cycle its
//   predecessor's result is taken or any later cycle
// - the output register holds its result while the receiver stalls, and no
//   new request is taken until the result is taken
// - reset clears all slot valid marks, so the store reads as empty
`default_nettype none

module ternary_pattern_memory_match #(
    parameter int SLOT_COUNT = tpm_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // elem_0 .. elem_7, 2 bits each
    input  wire logic [tpm_pkg::PAT_W-1:0]          i_s_axis_tdata,
    // req_type
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // best_score[4:0], best_active[8:5], slot_index[12:9], zero fill
    output logic [tpm_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    // found[0], table_full[1]
    output logic [1:0]                              o_m_axis_tuser
);
    import tpm_pkg::*;

    localparam int DEPTH = tree_depth(SLOT_COUNT);
    localparam int CNT_W = $clog2(DEPTH + 2);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_req_type;
    logic [PAT_W-1:0]        r_query;
    logic [SLOT_COUNT-1:0]   r_valid;
    logic [PAT_W-1:0]        r_pat [SLOT_COUNT];
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    s_accept;
    logic                    m_accept;
    logic [SLOT_COUNT-1:0]   free_vec;
    logic [SLOT_COUNT-1:0]   free_onehot;
    logic [SLOT_IDX_W-1:0]   free_slot;
    logic                    table_full;
    logic                    do_store;
    logic                    query_done;
    logic                    load_out;
    t_result                 n_out;
    wire t_node [SLOT_COUNT-1:0] lane_node;
    t_node                   root;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_accept        = r_out_valid && i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);

    // lowest free slot
    assign free_vec    = ~r_valid;
    assign free_onehot = free_vec & (~free_vec + SLOT_COUNT'(1));
    assign table_full  = (free_vec == '0);

    always_comb begin
        free_slot = '0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (free_onehot[s]) begin
                free_slot = free_slot | SLOT_IDX_W'(s);
            end
        end
    end

    for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_lane
        tpm_lane u_lane (
            .i_query (r_query),
            .i_word  (r_pat[s]),
            .i_valid (r_valid[s]),
            .i_slot  (SLOT_IDX_W'(s)),
            .o_node  (lane_node[s])
        );
    end

    tpm_merge_tree #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_merge (
        .i_clk  (i_clk),
        .i_leaf (lane_node),
        .o_root (root)
    );

    assign do_store   = (r_state == S_BUSY) && (r_req_type == REQ_STORE);
    assign query_done = (r_state == S_BUSY) && (r_req_type == REQ_QUERY)
                        && (r_cnt == CNT_W'(DEPTH + 1));
    assign load_out   = do_store || query_done;

    always_comb begin
        n_out = '0;
        if (r_req_type == REQ_STORE) begin
            n_out.found = !table_full;
            n_out.full  = table_full;
            n_out.slot  = table_full ? '0 : free_slot;
        end else begin
            n_out.found  = root.have;
            n_out.score  = root.score;
            n_out.active = root.active;
            n_out.slot   = root.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_accept) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_cnt   <= '0;
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (load_out) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (do_store) begin
                            r_valid <= r_valid | free_onehot;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a slot is only ever written while free; stale content is never cleared but is masked by its valid mark
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req_type <= i_s_axis_tuser;
            r_query    <= i_s_axis_tdata;
        end
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (do_store && free_onehot[s]) begin
                r_pat[s] <= r_query;
            end
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - SLOT_IDX_W - ACT_W - SCORE_W)'(0),
                              r_out.slot, r_out.active, r_out.score};
    assign o_m_axis_tuser  = {r_out.full, r_out.found};

    a_out_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_BUSY))
        else $error("result appeared without a request in progress");

    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUSY) |-> !o_s_axis_tready)
        else $error("request accepted while busy");

    a_found_xor_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.found && r_out.full))
        else $error("result both found and table full");

    a_full_means_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.full) |-> (r_valid == '1))
        else $error("table full reported with a free slot");

    a_store_marks_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_store && !table_full) |=> ($countones(r_valid) == $countones($past(r_valid)) + 1))
        else $error("store did not claim exactly one slot");

endmodule

`default_nettype wire
